### hdl/sdsh_pkg.sv
// Package for the SD card SPI-mode sector host: field widths, status codes,
// register indexes and command frame constants. No dependencies.
`timescale 1ns / 1ps
package sdsh_pkg;
	localparam int SECTOR_BYTES_C = 512;
	localparam int RESPONSE_POLL_BYTES_C = 10;
	localparam int INIT_CLOCK_BYTES_C = 80;
	localparam int CMD0_GAP_BYTES = 20;
	localparam int WRITE_LEAD_BYTES = 10;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0, OP_INIT = 2'd1, OP_READ = 2'd2, OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_CMD0 = 4'd1, ST_CMD8 = 4'd2, ST_ACMD41 = 4'd3, ST_CMD58 = 4'd4,
		ST_CMD_REJ = 4'd5, ST_TOKEN = 4'd6, ST_DATA_REJ = 4'd7, ST_BUSY = 4'd8
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_READY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOKEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUSY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACMD41 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CMD0 = 3'd4;

	localparam logic [5:0] CMD0 = 6'd0;
	localparam logic [5:0] CMD8 = 6'd8;
	localparam logic [5:0] CMD17 = 6'd17;
	localparam logic [5:0] CMD24 = 6'd24;
	localparam logic [5:0] CMD41 = 6'd41;
	localparam logic [5:0] CMD55 = 6'd55;
	localparam logic [5:0] CMD58 = 6'd58;

	localparam logic [7:0] IDLE_BYTE = 8'hFF;
	localparam logic [7:0] DATA_TOKEN = 8'hFE;
	localparam logic [7:0] R1_IDLE = 8'h01;
	localparam logic [7:0] R1_READY = 8'h00;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] sector;
		logic [7:0]  miso_byte;
		logic [7:0]  write_byte;
	} in_item_t;

	typedef struct packed {
		logic        exchange_valid;
		logic [7:0]  mosi_byte;
		logic        cs_asserted;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic        read_last;
		logic        write_taken;
		logic        done_res;
		logic [3:0]  status;
	} out_item_t;

	function automatic logic [47:0] make_frame(logic [5:0] cmd, logic [31:0] arg);
		logic [7:0] crc;
		crc = (cmd == CMD0) ? 8'h95 : ((cmd == CMD8) ? 8'h87 : 8'hFF);
		return {2'b01, cmd, arg, crc};
	endfunction
endpackage

### hdl/sdsh_stream_if.sv
// Valid/ready channel carrying one payload item. Depends on nothing.
`timescale 1ns / 1ps
interface sdsh_stream_if #(parameter type item_t = logic) (input logic clk);
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/sd_spi_sector_host_core.sv
// SD card SPI-mode sector host: the sequencer that picks the next SPI byte.
// Depends on sdsh_pkg and sdsh_stream_if.
//
// Each accepted item is one SPI byte exchange and yields one result item; the
// sequencer decides the next byte combinationally from the state registers, so
// an item is accepted every cycle unless the output stalls. The result waits in
// an output register; a new item is taken whenever it is empty or being drained.
`timescale 1ns / 1ps
module sd_spi_sector_host_core #(
	parameter int RESPONSE_POLL_BYTES = sdsh_pkg::RESPONSE_POLL_BYTES_C,
	parameter int INIT_CLOCK_BYTES = sdsh_pkg::INIT_CLOCK_BYTES_C
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sdsh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdsh_pkg::CFG_W-1:0]     cfg_data,
	sdsh_stream_if.sink                  in_ch,
	sdsh_stream_if.source                out_ch
);
	import sdsh_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_CLOCKS, PH_GAP, PH_CMD_DESEL, PH_CMD_READY, PH_CMD_FRAME,
		PH_CMD_RESP, PH_CMD_NOTREADY, PH_CMD0_GAP, PH_R7, PH_OCR, PH_TOKEN,
		PH_RDATA, PH_RCRC, PH_WLEAD, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP,
		PH_WBUSY, PH_WREADY
	} phase_t;

	logic [23:0] ready_lim_q;
	logic [15:0] token_lim_q, busy_lim_q, acmd_lim_q;
	logic [7:0]  cmd0_lim_q;

	phase_t      phase_q, phase_d;
	logic        block_addr_q, block_addr_d;
	logic [47:0] frame_q, frame_d;
	logic [9:0]  bcnt_q, bcnt_d;
	logic [23:0] pcnt_q, pcnt_d;
	logic [15:0] rcnt_q, rcnt_d;
	logic [7:0]  ocr_q, ocr_d;
	out_item_t   res, out_q;
	logic        out_v_q;
	logic        take;

	in_item_t    it;
	logic [23:0] pcnt_inc;
	logic [15:0] rcnt_inc;
	logic [7:0]  miso;
	logic [7:0]  rsp;
	logic        do_rsp;

	assign it = in_ch.data;
	assign miso = it.miso_byte;
	assign in_ch.ready = !out_v_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
	assign pcnt_inc = pcnt_q + 24'd1;
	assign rcnt_inc = rcnt_q + 16'd1;

	function automatic logic [7:0] fbyte(logic [47:0] f, logic [9:0] i);
		logic [7:0] b;
		case (i[2:0])
			3'd0: b = f[47:40];
			3'd1: b = f[39:32];
			3'd2: b = f[31:24];
			3'd3: b = f[23:16];
			3'd4: b = f[15:8];
			default: b = f[7:0];
		endcase
		return b;
	endfunction

	always_comb begin
		logic [31:0] addr;
		phase_d = phase_q;
		block_addr_d = block_addr_q;
		frame_d = frame_q;
		bcnt_d = bcnt_q;
		pcnt_d = pcnt_q;
		rcnt_d = rcnt_q;
		ocr_d = ocr_q;
		res = '0;
		do_rsp = 1'b0;
		rsp = miso;
		addr = block_addr_q ? it.sector : {it.sector[22:0], 9'd0};
		case (phase_q)
			PH_IDLE: begin
				if (it.op == OP_INIT) begin
					bcnt_d = '0;
					res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
					phase_d = PH_CLOCKS;
				end else if (it.op == OP_READ || it.op == OP_WRITE) begin
					rcnt_d = '0;
					frame_d = make_frame((it.op == OP_READ) ? CMD17 : CMD24, addr);
					res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
					phase_d = PH_CMD_DESEL;
				end
			end
			PH_CLOCKS: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
				if (32'(bcnt_q) + 32'd1 < 32'(INIT_CLOCK_BYTES)) bcnt_d = bcnt_q + 10'd1;
				else begin
					rcnt_d = '0; frame_d = make_frame(CMD0, '0); phase_d = PH_CMD_DESEL;
				end
			end
			PH_GAP: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
				phase_d = PH_CMD_DESEL;
			end
			PH_CMD_DESEL: begin
				pcnt_d = '0;
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				phase_d = PH_CMD_READY;
			end
			PH_CMD_READY: begin
				pcnt_d = pcnt_inc;
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				if (miso == IDLE_BYTE) begin
					bcnt_d = '0; res.mosi_byte = frame_q[47:40]; phase_d = PH_CMD_FRAME;
				end else if (pcnt_inc >= ready_lim_q) begin
					res.cs_asserted = 1'b0; phase_d = PH_CMD_NOTREADY;
				end
			end
			PH_CMD_FRAME: begin
				res.exchange_valid = 1'b1; res.cs_asserted = 1'b1; res.mosi_byte = IDLE_BYTE;
				if (bcnt_q < 10'd5) begin
					bcnt_d = bcnt_q + 10'd1; res.mosi_byte = fbyte(frame_q, bcnt_q + 10'd1);
				end else begin
					pcnt_d = 24'd1; phase_d = PH_CMD_RESP;
				end
			end
			PH_CMD_RESP: begin
				if (!miso[7] || 32'(pcnt_q) >= 32'(RESPONSE_POLL_BYTES)) do_rsp = 1'b1;
				else begin
					pcnt_d = pcnt_inc;
					res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				end
			end
			PH_CMD_NOTREADY: begin
				do_rsp = 1'b1; rsp = IDLE_BYTE;
			end
			PH_CMD0_GAP: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
				if (32'(bcnt_q) < CMD0_GAP_BYTES) bcnt_d = bcnt_q + 10'd1;
				else begin
					frame_d = make_frame(CMD0, '0); phase_d = PH_CMD_DESEL;
				end
			end
			PH_R7: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
				if (bcnt_q < 10'd3) begin
					bcnt_d = bcnt_q + 10'd1; res.cs_asserted = 1'b1;
				end else begin
					rcnt_d = '0; frame_d = make_frame(CMD55, '0); phase_d = PH_GAP;
				end
			end
			PH_OCR: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
				if (bcnt_q == '0) ocr_d = miso;
				if (bcnt_q < 10'd3) begin
					bcnt_d = bcnt_q + 10'd1; res.cs_asserted = 1'b1;
				end else begin
					block_addr_d = ocr_q[6];
					res.done_res = 1'b1; res.status = ST_OK; phase_d = PH_IDLE;
				end
			end
			PH_TOKEN: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				if (miso == DATA_TOKEN) begin
					bcnt_d = '0; phase_d = PH_RDATA;
				end else begin
					pcnt_d = pcnt_inc;
					if (pcnt_inc >= {8'd0, token_lim_q}) begin
						res.cs_asserted = 1'b0; res.done_res = 1'b1; res.status = ST_TOKEN;
						phase_d = PH_IDLE;
					end
				end
			end
			PH_RDATA: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				res.read_valid = 1'b1; res.read_byte = miso;
				res.read_last = (bcnt_q == 10'(SECTOR_BYTES_C - 1));
				if (bcnt_q < 10'(SECTOR_BYTES_C - 1)) bcnt_d = bcnt_q + 10'd1;
				else begin
					bcnt_d = '0; phase_d = PH_RCRC;
				end
			end
			PH_RCRC: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
				if (bcnt_q == '0) begin
					bcnt_d = 10'd1; res.cs_asserted = 1'b1;
				end else begin
					res.done_res = 1'b1; res.status = ST_OK; phase_d = PH_IDLE;
				end
			end
			PH_WLEAD: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				if (32'(bcnt_q) < WRITE_LEAD_BYTES - 1) bcnt_d = bcnt_q + 10'd1;
				else begin
					res.mosi_byte = DATA_TOKEN; phase_d = PH_WTOKEN;
				end
			end
			PH_WTOKEN: begin
				bcnt_d = '0;
				res.exchange_valid = 1'b1; res.mosi_byte = it.write_byte; res.cs_asserted = 1'b1;
				res.write_taken = 1'b1; phase_d = PH_WDATA;
			end
			PH_WDATA: begin
				res.exchange_valid = 1'b1; res.cs_asserted = 1'b1;
				if (bcnt_q < 10'(SECTOR_BYTES_C - 1)) begin
					bcnt_d = bcnt_q + 10'd1; res.mosi_byte = it.write_byte; res.write_taken = 1'b1;
				end else begin
					bcnt_d = '0; res.mosi_byte = IDLE_BYTE; phase_d = PH_WCRC;
				end
			end
			PH_WCRC: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				if (bcnt_q == '0) bcnt_d = 10'd1;
				else phase_d = PH_WRESP;
			end
			PH_WRESP: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
				if (miso[4:0] != 5'h05) begin
					res.done_res = 1'b1; res.status = ST_DATA_REJ; phase_d = PH_IDLE;
				end else begin
					pcnt_d = '0; res.cs_asserted = 1'b1; phase_d = PH_WBUSY;
				end
			end
			PH_WBUSY: begin
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				rcnt_d = '0;
				if (miso != 8'h00) begin
					pcnt_d = '0; phase_d = PH_WREADY;
				end else if (pcnt_inc >= {8'd0, busy_lim_q}) begin
					rcnt_d = 16'd1; pcnt_d = '0; phase_d = PH_WREADY;
				end else pcnt_d = pcnt_inc;
			end
			PH_WREADY: begin
				pcnt_d = pcnt_inc;
				res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE; res.cs_asserted = 1'b1;
				if (miso == IDLE_BYTE || pcnt_inc >= ready_lim_q) begin
					res.cs_asserted = 1'b0; res.done_res = 1'b1;
					res.status = (rcnt_q != '0) ? ST_BUSY : ST_OK; phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		if (do_rsp) begin
			res = '0;
			res.exchange_valid = 1'b1; res.mosi_byte = IDLE_BYTE;
			case (frame_q[45:40])
				CMD0: begin
					if (rsp == R1_IDLE) begin
						frame_d = make_frame(CMD8, 32'h0000_01AA); phase_d = PH_CMD_DESEL;
					end else begin
						rcnt_d = rcnt_inc;
						if (rcnt_inc >= {8'd0, cmd0_lim_q}) begin
							res.done_res = 1'b1; res.status = ST_CMD0; phase_d = PH_IDLE;
						end else begin
							bcnt_d = '0; phase_d = PH_CMD0_GAP;
						end
					end
				end
				CMD8: begin
					if (rsp != R1_IDLE) begin
						res.done_res = 1'b1; res.status = ST_CMD8; phase_d = PH_IDLE;
					end else begin
						res.cs_asserted = 1'b1; bcnt_d = '0; phase_d = PH_R7;
					end
				end
				CMD55: begin
					frame_d = make_frame(CMD41, 32'h4000_0000); phase_d = PH_GAP;
				end
				CMD41: begin
					if (rsp == R1_READY) begin
						frame_d = make_frame(CMD58, '0); phase_d = PH_GAP;
					end else begin
						rcnt_d = rcnt_inc;
						if (rcnt_inc >= acmd_lim_q) begin
							res.done_res = 1'b1; res.status = ST_ACMD41; phase_d = PH_IDLE;
						end else begin
							frame_d = make_frame(CMD55, '0); phase_d = PH_GAP;
						end
					end
				end
				CMD58: begin
					if (rsp != R1_READY) begin
						res.done_res = 1'b1; res.status = ST_CMD58; phase_d = PH_IDLE;
					end else begin
						res.cs_asserted = 1'b1; bcnt_d = '0; phase_d = PH_OCR;
					end
				end
				CMD17: begin
					if (rsp != R1_READY) begin
						res.done_res = 1'b1; res.status = ST_CMD_REJ; phase_d = PH_IDLE;
					end else begin
						res.cs_asserted = 1'b1; pcnt_d = '0; phase_d = PH_TOKEN;
					end
				end
				CMD24: begin
					if (rsp != R1_READY) begin
						res.done_res = 1'b1; res.status = ST_CMD_REJ; phase_d = PH_IDLE;
					end else begin
						res.cs_asserted = 1'b1; bcnt_d = '0; phase_d = PH_WLEAD;
					end
				end
				default: begin
					res.done_res = 1'b1; res.status = ST_CMD_REJ; phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_lim_q <= 24'd625000;
			token_lim_q <= 16'd10000;
			busy_lim_q <= 16'd60000;
			acmd_lim_q <= 16'd1000;
			cmd0_lim_q <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_READY: ready_lim_q <= cfg_data;
				REG_TOKEN: token_lim_q <= cfg_data[15:0];
				REG_BUSY: busy_lim_q <= cfg_data[15:0];
				REG_ACMD41: acmd_lim_q <= cfg_data[15:0];
				REG_CMD0: cmd0_lim_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			block_addr_q <= 1'b0;
			frame_q <= '0;
			bcnt_q <= '0;
			pcnt_q <= '0;
			rcnt_q <= '0;
			ocr_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				block_addr_q <= block_addr_d;
				frame_q <= frame_d;
				bcnt_q <= bcnt_d;
				pcnt_q <= pcnt_d;
				rcnt_q <= rcnt_d;
				ocr_q <= ocr_d;
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.done_res |=> phase_q == PH_IDLE)
		else $error("done without return to idle");
	a_done_desel: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.done_res |-> !out_q.cs_asserted && out_q.exchange_valid)
		else $error("done byte must deselect");
	a_read_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.read_valid |-> out_q.cs_asserted)
		else $error("read data outside selection");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q && $stable(out_q))
		else $error("stalled result changed");
`endif
endmodule

### verif/tb_top.sv
// Testbench for sd_spi_sector_host_core: drives SPI byte exchanges from a simple
// card responder, predicts every result item and checks it field by field.
// Depends on sdsh_pkg, sdsh_stream_if and the core.
`timescale 1ns / 1ps
module tb_top;
	import sdsh_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CLOCKS, S_GAP, S_DESEL, S_READY, S_FRAME, S_RESP, S_NOTREADY,
		S_CMD0_GAP, S_R7, S_OCR, S_TOKEN, S_RDATA, S_RCRC, S_WLEAD, S_WTOKEN,
		S_WDATA, S_WCRC, S_WRESP, S_WBUSY, S_WREADY
	} host_phase_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	sdsh_stream_if #(.item_t(in_item_t)) in_ch (.clk(clk));
	sdsh_stream_if #(.item_t(out_item_t)) out_ch (.clk(clk));

	sd_spi_sector_host_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// host model state
	logic [23:0] lim_ready = 24'd625000;
	logic [15:0] lim_token = 16'd10000;
	logic [15:0] lim_busy = 16'd60000;
	logic [15:0] lim_acmd41 = 16'd1000;
	logic [7:0]  lim_cmd0 = 8'd10;
	host_phase_t ph = S_IDLE;
	logic        blk_addr = 0;
	logic [47:0] frame = '0;
	logic [9:0]  bcnt = '0;
	logic [23:0] pcnt = '0;
	logic [15:0] rcnt = '0;
	logic [31:0] addr = '0;
	logic [7:0]  ocr0 = '0;
	out_item_t   nxt;

	out_item_t exp_q[$];
	int errs = 0;
	int burst_left = 0;
	int sent = 0;
	bit hold_req = 0;
	int quiet = 0;

	function automatic void give(logic [7:0] b, logic cs);
		nxt.exchange_valid = 1'b1;
		nxt.mosi_byte = b;
		nxt.cs_asserted = cs;
	endfunction

	function automatic void conclude(status_t st);
		give(IDLE_BYTE, 1'b0);
		nxt.done_res = 1'b1;
		nxt.status = st;
		ph = S_IDLE;
	endfunction

	function automatic void launch(logic [5:0] cmd, logic [31:0] arg, bit gap);
		logic [7:0] crc;
		crc = (cmd == CMD0) ? 8'h95 : ((cmd == CMD8) ? 8'h87 : 8'hFF);
		frame = {2'b01, cmd, arg, crc};
		give(IDLE_BYTE, 1'b0);
		ph = gap ? S_GAP : S_DESEL;
	endfunction

	function automatic logic [7:0] frame_at(int i);
		return frame[(5 - i) * 8 +: 8];
	endfunction

	function automatic void judge_r1(logic [7:0] r);
		case (frame[45:40])
			CMD0: begin
				if (r == R1_IDLE) launch(CMD8, 32'h0000_01AA, 0);
				else begin
					rcnt = rcnt + 1'b1;
					if (rcnt >= {8'd0, lim_cmd0}) conclude(ST_CMD0);
					else begin
						give(IDLE_BYTE, 1'b0);
						bcnt = 0;
						ph = S_CMD0_GAP;
					end
				end
			end
			CMD8: begin
				if (r != R1_IDLE) conclude(ST_CMD8);
				else begin
					give(IDLE_BYTE, 1'b1);
					bcnt = 0;
					ph = S_R7;
				end
			end
			CMD55: launch(CMD41, 32'h4000_0000, 1);
			CMD41: begin
				if (r == R1_READY) launch(CMD58, 32'd0, 1);
				else begin
					rcnt = rcnt + 1'b1;
					if (rcnt >= lim_acmd41) conclude(ST_ACMD41);
					else launch(CMD55, 32'd0, 1);
				end
			end
			CMD58: begin
				if (r != R1_READY) conclude(ST_CMD58);
				else begin
					give(IDLE_BYTE, 1'b1);
					bcnt = 0;
					ph = S_OCR;
				end
			end
			CMD17: begin
				if (r != R1_READY) conclude(ST_CMD_REJ);
				else begin
					give(IDLE_BYTE, 1'b1);
					pcnt = 0;
					ph = S_TOKEN;
				end
			end
			CMD24: begin
				if (r != R1_READY) conclude(ST_CMD_REJ);
				else begin
					give(IDLE_BYTE, 1'b1);
					bcnt = 0;
					ph = S_WLEAD;
				end
			end
			default: conclude(ST_CMD_REJ);
		endcase
	endfunction

	function automatic out_item_t predict_exchange(in_item_t it);
		logic [7:0] m;
		bit go;
		m = it.miso_byte;
		nxt = '0;
		case (ph)
			S_IDLE: begin
				if (it.op == OP_INIT) begin
					bcnt = 0;
					give(IDLE_BYTE, 1'b0);
					ph = S_CLOCKS;
				end else if (it.op == OP_READ || it.op == OP_WRITE) begin
					addr = blk_addr ? it.sector : {it.sector[22:0], 9'd0};
					rcnt = 0;
					launch(it.op == OP_READ ? CMD17 : CMD24, addr, 0);
				end
			end
			S_CLOCKS: begin
				if (int'(bcnt) + 1 < INIT_CLOCK_BYTES_C) begin
					bcnt = bcnt + 1'b1;
					give(IDLE_BYTE, 1'b0);
				end else begin
					rcnt = 0;
					launch(CMD0, 32'd0, 0);
				end
			end
			S_GAP: begin
				give(IDLE_BYTE, 1'b0);
				ph = S_DESEL;
			end
			S_DESEL: begin
				pcnt = 0;
				give(IDLE_BYTE, 1'b1);
				ph = S_READY;
			end
			S_READY: begin
				pcnt = pcnt + 1'b1;
				if (m == IDLE_BYTE) begin
					bcnt = 0;
					give(frame_at(0), 1'b1);
					ph = S_FRAME;
				end else if (pcnt >= lim_ready) begin
					give(IDLE_BYTE, 1'b0);
					ph = S_NOTREADY;
				end else give(IDLE_BYTE, 1'b1);
			end
			S_FRAME: begin
				if (bcnt < 5) begin
					bcnt = bcnt + 1'b1;
					give(frame_at(int'(bcnt)), 1'b1);
				end else begin
					pcnt = 1;
					give(IDLE_BYTE, 1'b1);
					ph = S_RESP;
				end
			end
			S_RESP: begin
				if (!m[7] || pcnt >= RESPONSE_POLL_BYTES_C) judge_r1(m);
				else begin
					pcnt = pcnt + 1'b1;
					give(IDLE_BYTE, 1'b1);
				end
			end
			S_NOTREADY: judge_r1(IDLE_BYTE);
			S_CMD0_GAP: begin
				if (bcnt < CMD0_GAP_BYTES) begin
					bcnt = bcnt + 1'b1;
					give(IDLE_BYTE, 1'b0);
				end else launch(CMD0, 32'd0, 0);
			end
			S_R7: begin
				if (bcnt < 3) begin
					bcnt = bcnt + 1'b1;
					give(IDLE_BYTE, 1'b1);
				end else begin
					rcnt = 0;
					launch(CMD55, 32'd0, 1);
				end
			end
			S_OCR: begin
				if (bcnt == 0) ocr0 = m;
				if (bcnt < 3) begin
					bcnt = bcnt + 1'b1;
					give(IDLE_BYTE, 1'b1);
				end else begin
					blk_addr = ocr0[6];
					conclude(ST_OK);
				end
			end
			S_TOKEN: begin
				if (m == DATA_TOKEN) begin
					bcnt = 0;
					give(IDLE_BYTE, 1'b1);
					ph = S_RDATA;
				end else begin
					pcnt = pcnt + 1'b1;
					if (pcnt >= lim_token) conclude(ST_TOKEN);
					else give(IDLE_BYTE, 1'b1);
				end
			end
			S_RDATA: begin
				nxt.read_valid = 1'b1;
				nxt.read_byte = m;
				nxt.read_last = (bcnt == SECTOR_BYTES_C - 1);
				give(IDLE_BYTE, 1'b1);
				if (bcnt < SECTOR_BYTES_C - 1) bcnt = bcnt + 1'b1;
				else begin
					bcnt = 0;
					ph = S_RCRC;
				end
			end
			S_RCRC: begin
				if (bcnt == 0) begin
					bcnt = 1;
					give(IDLE_BYTE, 1'b1);
				end else conclude(ST_OK);
			end
			S_WLEAD: begin
				if (bcnt < WRITE_LEAD_BYTES - 1) begin
					bcnt = bcnt + 1'b1;
					give(IDLE_BYTE, 1'b1);
				end else begin
					give(DATA_TOKEN, 1'b1);
					ph = S_WTOKEN;
				end
			end
			S_WTOKEN: begin
				bcnt = 0;
				give(it.write_byte, 1'b1);
				nxt.write_taken = 1'b1;
				ph = S_WDATA;
			end
			S_WDATA: begin
				if (bcnt < SECTOR_BYTES_C - 1) begin
					bcnt = bcnt + 1'b1;
					give(it.write_byte, 1'b1);
					nxt.write_taken = 1'b1;
				end else begin
					bcnt = 0;
					give(IDLE_BYTE, 1'b1);
					ph = S_WCRC;
				end
			end
			S_WCRC: begin
				give(IDLE_BYTE, 1'b1);
				if (bcnt == 0) bcnt = 1;
				else ph = S_WRESP;
			end
			S_WRESP: begin
				if (m[4:0] != 5'h05) conclude(ST_DATA_REJ);
				else begin
					pcnt = 0;
					give(IDLE_BYTE, 1'b1);
					ph = S_WBUSY;
				end
			end
			S_WBUSY: begin
				go = 0;
				rcnt = 0;
				if (m != 8'h00) go = 1;
				else begin
					pcnt = pcnt + 1'b1;
					if (pcnt >= lim_busy) begin
						rcnt = 1;
						go = 1;
					end
				end
				if (go) begin
					pcnt = 0;
					ph = S_WREADY;
				end
				give(IDLE_BYTE, 1'b1);
			end
			S_WREADY: begin
				pcnt = pcnt + 1'b1;
				if (m == IDLE_BYTE || pcnt >= lim_ready) conclude(rcnt != 0 ? ST_BUSY : ST_OK);
				else give(IDLE_BYTE, 1'b1);
			end
			default: ph = S_IDLE;
		endcase
		return nxt;
	endfunction

	// plausible card answer for the byte now on the bus, with some noise
	function automatic logic [7:0] card_byte();
		logic [7:0] r;
		r = 8'($urandom);
		if ($urandom_range(0, 19) == 0) return r;
		case (ph)
			S_READY: return ($urandom_range(0, 3) == 0) ? 8'h00 : IDLE_BYTE;
			S_RESP: begin
				if ($urandom_range(0, 3) == 0) return IDLE_BYTE;
				case (frame[45:40])
					CMD0, CMD8, CMD55: return ($urandom_range(0, 5) == 0) ? 8'h05 : R1_IDLE;
					CMD41: return ($urandom_range(0, 2) == 0) ? R1_READY : R1_IDLE;
					default: return ($urandom_range(0, 7) == 0) ? 8'h04 : R1_READY;
				endcase
			end
			S_TOKEN: return ($urandom_range(0, 2) == 0) ? DATA_TOKEN : IDLE_BYTE;
			S_WRESP: return {r[7:5], ($urandom_range(0, 5) == 0) ? 5'h0B : 5'h05};
			S_WBUSY: return ($urandom_range(0, 3) == 0) ? (r | 8'h01) : 8'h00;
			S_WREADY: return ($urandom_range(0, 2) == 0) ? IDLE_BYTE : 8'h00;
			default: return r;
		endcase
	endfunction

	task automatic put(in_item_t it);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		exp_q.push_back(predict_exchange(it));
		sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end
	endtask

	task automatic run_op(op_t op, logic [31:0] sector);
		in_item_t it;
		it = {op, sector, 8'($urandom), 8'($urandom)};
		put(it);
		while (ph != S_IDLE) begin
			it.op = ($urandom_range(0, 19) == 0) ? op_t'($urandom_range(1, 3)) : OP_BYTE;
			it.sector = $urandom;
			it.miso_byte = card_byte();
			it.write_byte = $urandom;
			put(it);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (exp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_READY: lim_ready = val;
			REG_TOKEN: lim_token = val[15:0];
			REG_BUSY: lim_busy = val[15:0];
			REG_ACMD41: lim_acmd41 = val[15:0];
			REG_CMD0: lim_cmd0 = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(logic [23:0] rd, logic [15:0] tk, logic [15:0] bz,
			logic [15:0] ac, logic [7:0] c0);
		drain();
		set_reg(REG_READY, rd);
		set_reg(REG_TOKEN, {8'd0, tk});
		set_reg(REG_BUSY, {8'd0, bz});
		set_reg(REG_ACMD41, {8'd0, ac});
		set_reg(REG_CMD0, {16'd0, c0});
	endtask

	task automatic test_idle_bytes();
		put({OP_BYTE, 32'h0000_0000, 8'h00, 8'h00});
		put({OP_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'hFF});
		put({OP_BYTE, 32'hA5A5_5A5A, 8'h5A, 8'hA5});
	endtask

	task automatic test_zero_limits();
		set_limits('0, '0, '0, '0, '0);
		run_op(OP_INIT, 32'd0);
		run_op(OP_READ, 32'hFFFF_FFFF);
	endtask

	task automatic test_max_limits();
		set_limits(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		run_op(OP_INIT, 32'd0);
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		run_op(OP_INIT, $urandom);
		drain();
	endtask

	task automatic test_random_ops();
		int n;
		set_limits(24'd3, 16'd5, 16'd6, 16'd4, 8'd3);
		n = 0;
		while (sent < 850 || n < 4) begin
			case ($urandom_range(0, 3))
				0, 1: run_op(OP_INIT, $urandom);
				2: run_op(OP_READ, $urandom);
				default: run_op(OP_WRITE, $urandom);
			endcase
			if ($urandom_range(0, 4) == 0) put({OP_BYTE, 32'($urandom), 8'($urandom), 8'($urandom)});
			n++;
			if (n % 6 == 0) drain();
			if (n % 10 == 0)
				set_limits(24'($urandom_range(1, 8)), 16'($urandom_range(1, 12)),
					16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
					8'($urandom_range(1, 4)));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_zero_limits();
		test_max_limits();
		test_backpressure();
		test_random_ops();
		in_ch.valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (errs == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	// receiver: changing stall patterns plus one long hold
	initial begin
		int mode;
		int seg;
		int hold;
		int cyc;
		out_ch.ready = 1'b0;
		mode = 0;
		seg = 0;
		hold = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req && hold == 0) begin
				hold = 300;
				hold_req = 0;
			end
			if (seg == 0) begin
				mode = $urandom_range(0, 2);
				seg = $urandom_range(20, 200);
			end
			seg--;
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 9) < 7);
				default: out_ch.ready <= (cyc % 5 != 0);
			endcase
		end
	end

	task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0h, got %0h", name, e, a);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t e;
		out_item_t a;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			a = out_ch.data;
			if (exp_q.size() == 0) begin
				$error("unexpected result item %h", a);
				errs++;
			end else begin
				e = exp_q.pop_front();
				cmp_field("exchange_valid", e.exchange_valid, a.exchange_valid);
				cmp_field("mosi_byte", e.mosi_byte, a.mosi_byte);
				cmp_field("cs_asserted", e.cs_asserted, a.cs_asserted);
				cmp_field("read_valid", e.read_valid, a.read_valid);
				cmp_field("read_byte", e.read_byte, a.read_byte);
				cmp_field("read_last", e.read_last, a.read_last);
				cmp_field("write_taken", e.write_taken, a.write_taken);
				cmp_field("done_res", e.done_res, a.done_res);
				cmp_field("status", e.status, a.status);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end
endmodule
